// ===== rtl/ray_refract_reflect_direction_macros.svh =====
// Assertion macros for the ray direction unit.
`ifndef RAY_REFRACT_REFLECT_DIRECTION_MACROS_SVH
`define RAY_REFRACT_REFLECT_DIRECTION_MACROS_SVH
`ifndef SYNTHESIS
`define RRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rrd: property failed");
`define RRD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rrd: forbidden condition seen");
`else
`define RRD_ASSERT(lbl, prop)
`define RRD_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/rrd_pkg.sv =====
// Shared types and constants of the ray direction unit.
package rrd_pkg;

  localparam int RRD_RAD_W     = 56;
  localparam int RRD_ROOT_W    = 28;
  localparam int RRD_SQ_STAGES = 14;
  // edges from the accepting edge to the one that raises out_valid
  localparam int RRD_LAT       = 22;

  localparam logic signed [45:0] RRD_ONE_Q28  = 46'sd268435456;
  localparam logic signed [57:0] RRD_HALF_Q42 = 58'sd134217728;

  typedef struct packed {
    logic                 cmd;
    logic                 tir;
    logic                 refr;
    logic [15:0]          eta;
    logic [37:0]          etacos;
    logic [33:0]          nv;
    logic [2:0][32:0]     ev;
    logic [2:0][15:0]     v;
    logic [2:0][15:0]     n;
  } rrd_side_t;

  typedef struct packed {
    logic                 vld;
    logic [RRD_RAD_W-1:0] a;
    logic [RRD_RAD_W-1:0] res;
    rrd_side_t            side;
  } rrd_sq_t;

endpackage

// ===== rtl/rrd_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
module rrd_isqrt
  import rrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  rrd_sq_t sq_in,
  output rrd_sq_t sq_out
);

  rrd_sq_t stg_r [RRD_SQ_STAGES];

  function automatic rrd_sq_t sq_step(rrd_sq_t s, logic [RRD_RAD_W-1:0] bv);
    logic [RRD_RAD_W:0] trial;
    rrd_sq_t            o;
    o     = s;
    trial = {1'b0, s.res} + {1'b0, bv};
    if ({1'b0, s.a} >= trial) begin
      o.a   = s.a - trial[RRD_RAD_W-1:0];
      o.res = (s.res >> 1) + bv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  for (genvar j = 0; j < RRD_SQ_STAGES; j++) begin : g_stage
    localparam logic [RRD_RAD_W-1:0] B0 = RRD_RAD_W'(1) << (RRD_RAD_W - 2 - 4 * j);
    localparam logic [RRD_RAD_W-1:0] B1 = RRD_RAD_W'(1) << (RRD_RAD_W - 4 - 4 * j);
    rrd_sq_t prv;
    rrd_sq_t stg_nxt;
    if (j == 0) begin : g_first
      assign prv = sq_in;
    end else begin : g_rest
      assign prv = stg_r[j-1];
    end
    assign stg_nxt = sq_step(sq_step(prv, B0), B1);
    always_ff @(posedge clk) begin
      stg_r[j] <= stg_nxt;
      if (!rst_n) begin
        stg_r[j].vld <= 1'b0;
      end
    end
  end

  assign sq_out = stg_r[RRD_SQ_STAGES-1];

endmodule

// ===== rtl/ray_refract_reflect_direction.sv =====
// Throughput: one item per cycle; busy is always low, no stall path exists.
// The 14-stage square root (two root bits per stage) makes up most of the depth.
// Reset (rst_n low, synchronous) clears all valid bits; no result appears
// for items in flight at reset.
`include "ray_refract_reflect_direction_macros.svh"
module ray_refract_reflect_direction
  import rrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic signed [15:0] in_inc_x,
  input  logic signed [15:0] in_inc_y,
  input  logic signed [15:0] in_inc_z,
  input  logic signed [15:0] in_nrm_x,
  input  logic signed [15:0] in_nrm_y,
  input  logic signed [15:0] in_nrm_z,
  input  logic        [15:0] in_eta,
  output logic               out_valid,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_tir
);

  logic signed [15:0] inv [3];
  logic signed [15:0] nrm [3];
  assign inv[0] = in_inc_x;
  assign inv[1] = in_inc_y;
  assign inv[2] = in_inc_z;
  assign nrm[0] = in_nrm_x;
  assign nrm[1] = in_nrm_y;
  assign nrm[2] = in_nrm_z;

  assign busy = 1'b0;

  // stage 1: v.n products and eta*v
  rrd_side_t          side1_nxt, side1_r;
  logic signed [31:0] vn1_r [3];
  logic               vld1_r;

  always_comb begin
    side1_nxt     = '0;
    side1_nxt.cmd = in_cmd;
    side1_nxt.eta = in_eta;
    for (int i = 0; i < 3; i++) begin
      side1_nxt.v[i]  = inv[i];
      side1_nxt.n[i]  = nrm[i];
      side1_nxt.ev[i] = $signed({1'b0, in_eta}) * inv[i];
    end
  end

  always_ff @(posedge clk) begin
    vld1_r  <= start;
    side1_r <= side1_nxt;
    for (int i = 0; i < 3; i++) begin
      vn1_r[i] <= inv[i] * nrm[i];
    end
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end
  end

  // stage 2: cosI = -(v.n)
  logic signed [33:0] cosi2_nxt, cosi2_r;
  rrd_side_t          side2_r;
  logic               vld2_r;

  assign cosi2_nxt = -(34'(vn1_r[0]) + 34'(vn1_r[1]) + 34'(vn1_r[2]));

  always_ff @(posedge clk) begin
    vld2_r  <= vld1_r;
    side2_r <= side1_r;
    cosi2_r <= cosi2_nxt;
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end
  end

  // stage 3: cosI^2, eta*cosI, max(cosI,0)
  logic        [33:0] mag3;
  logic        [63:0] sq3_nxt, sq3_r;
  logic signed [50:0] ec3;
  rrd_side_t          side3_nxt, side3_r;
  logic               vld3_r;

  always_comb begin
    mag3             = cosi2_r[33] ? 34'(-cosi2_r) : cosi2_r;
    sq3_nxt          = mag3[31:0] * mag3[31:0];
    ec3              = $signed({1'b0, side2_r.eta}) * cosi2_r;
    side3_nxt        = side2_r;
    side3_nxt.etacos = ec3[50:13];
    side3_nxt.nv     = cosi2_r[33] ? '0 : cosi2_r;
  end

  always_ff @(posedge clk) begin
    vld3_r  <= vld2_r;
    side3_r <= side3_nxt;
    sq3_r   <= sq3_nxt;
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end
  end

  // stage 4: eta*(1 - cosI^2)
  logic signed [37:0] om4;
  logic signed [54:0] eo4_nxt, eo4_r;
  rrd_side_t          side4_r;
  logic               vld4_r;

  assign om4     = 38'sd268435456 - $signed({2'b00, sq3_r[63:28]});
  assign eo4_nxt = $signed({1'b0, side3_r.eta}) * om4;

  always_ff @(posedge clk) begin
    vld4_r  <= vld3_r;
    side4_r <= side3_r;
    eo4_r   <= eo4_nxt;
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end
  end

  // stage 5: second eta factor
  logic signed [41:0] t5;
  logic signed [58:0] et5_nxt, et5_r;
  rrd_side_t          side5_r;
  logic               vld5_r;

  assign t5      = eo4_r[54:13];
  assign et5_nxt = $signed({1'b0, side4_r.eta}) * t5;

  always_ff @(posedge clk) begin
    vld5_r  <= vld4_r;
    side5_r <= side4_r;
    et5_r   <= et5_nxt;
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end
  end

  // stage 6: total internal reflection test, square root radicand
  logic signed [45:0]    sint6, rem6;
  logic [RRD_RAD_W-1:0]  rad6_nxt, rad6_r;
  rrd_side_t             side6_nxt, side6_r;
  logic                  vld6_r;

  always_comb begin
    sint6          = et5_r[58:13];
    rem6           = RRD_ONE_Q28 - sint6;
    side6_nxt      = side5_r;
    side6_nxt.tir  = side5_r.cmd && (sint6 > RRD_ONE_Q28);
    side6_nxt.refr = side5_r.cmd && !(sint6 > RRD_ONE_Q28);
    rad6_nxt       = side6_nxt.refr ? {rem6[41:0], 14'b0} : '0;
  end

  always_ff @(posedge clk) begin
    vld6_r  <= vld5_r;
    side6_r <= side6_nxt;
    rad6_r  <= rad6_nxt;
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end
  end

  rrd_sq_t sq_in, sq_out;

  always_comb begin
    sq_in      = '0;
    sq_in.vld  = vld6_r;
    sq_in.a    = rad6_r;
    sq_in.side = side6_r;
  end

  rrd_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .sq_in  (sq_in),
    .sq_out (sq_out)
  );

  // stage K: k = eta*cosI - cosT
  logic [RRD_ROOT_W-1:0] cost;
  logic signed [39:0]    kk_nxt, kk_r;
  rrd_side_t             sidek_r;
  logic                  vldk_r;

  assign cost   = sq_out.res[RRD_ROOT_W-1:0];
  assign kk_nxt = 40'($signed(sq_out.side.etacos)) - $signed({5'b0, cost, 7'b0});

  always_ff @(posedge clk) begin
    vldk_r  <= sq_out.vld;
    sidek_r <= sq_out.side;
    kk_r    <= kk_nxt;
    if (!rst_n) begin
      vldk_r <= 1'b0;
    end
  end

  // stage P: k*n and max(cosI,0)*n
  logic signed [55:0] kn_r [3];
  logic signed [49:0] rf_r [3];
  rrd_side_t          sidep_r;
  logic               vldp_r;

  always_ff @(posedge clk) begin
    vldp_r  <= vldk_r;
    sidep_r <= sidek_r;
    for (int i = 0; i < 3; i++) begin
      kn_r[i] <= kk_r * $signed(sidek_r.n[i]);
      rf_r[i] <= $signed(sidek_r.nv) * $signed(sidek_r.n[i]);
    end
    if (!rst_n) begin
      vldp_r <= 1'b0;
    end
  end

  // stage O: sum, round half up, saturate
  logic signed [57:0] sa [3];
  logic signed [57:0] sb [3];
  logic signed [57:0] sr [3];
  logic signed [29:0] q  [3];
  logic signed [15:0] dir_nxt [3];
  logic signed [15:0] dir_r   [3];
  logic               out_valid_r, out_tir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sa[i] = (58'($signed(sidep_r.ev[i])) <<< 15) + 58'(kn_r[i]);
      sb[i] = (58'($signed(sidep_r.v[i])) <<< 28) + (58'(rf_r[i]) <<< 1);
      sr[i] = (sidep_r.refr ? sa[i] : sb[i]) + RRD_HALF_Q42;
      q[i]  = sr[i][57:28];
      if (q[i] > 30'sd32767) begin
        dir_nxt[i] = 16'sh7fff;
      end else if (q[i] < -30'sd32768) begin
        dir_nxt[i] = 16'sh8000;
      end else begin
        dir_nxt[i] = q[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_valid_r <= vldp_r;
    out_tir_r   <= vldp_r && sidep_r.tir;
    for (int i = 0; i < 3; i++) begin
      dir_r[i] <= dir_nxt[i];
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_tir_r   <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tir   = out_tir_r;
  assign out_dir_x = dir_r[0];
  assign out_dir_y = dir_r[1];
  assign out_dir_z = dir_r[2];

  // out_valid is raised at edge RRD_LAT, so it is sampled high at the edge after that
  `RRD_ASSERT(a_lat_hi, start |-> ##(RRD_LAT + 1) out_valid)
  `RRD_ASSERT(a_lat_lo, !start |-> ##(RRD_LAT + 1) !out_valid)
  `RRD_NEVER(a_tir_idle, out_tir && !out_valid)

endmodule
